FILE: hw/rtl/som_pkg.sv
// Shared types and constants of the self-organizing map training block.
// No dependencies; every other RTL file of the block but som_ram imports it.
`default_nettype none
package som_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned LANE_W     = 16;
  localparam int unsigned VEC_W      = LANES * LANE_W;
  localparam int unsigned SQ_W       = 2 * LANE_W;
  localparam int unsigned SUM_W      = SQ_W + 2;
  localparam int unsigned ROOT_W     = SUM_W / 2;
  localparam int unsigned DIST_W     = 17;
  localparam int unsigned D2_W       = 11;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DIST_W-1:0] DIST_MAX  = 17'd131071;
  localparam logic [16:0]       LOG2E_Q16 = 17'd94548;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TRAIN = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS   = 3'd0,
    CFG_COLS   = 3'd1,
    CFG_FEATS  = 3'd2,
    CFG_ALPHA  = 3'd3,
    CFG_RADIUS = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [4:0]       node_row;
    logic [4:0]       node_col;
    logic [VEC_W-1:0] feature_vector;
  } req_t;

  typedef struct packed {
    logic [1:0]        resp_kind;
    logic [4:0]        bmu_row;
    logic [4:0]        bmu_col;
    logic [DIST_W-1:0] bmu_distance;
    logic [VEC_W-1:0]  node_vector;
  } resp_t;

  // 2^(-k/16) in Q16, k = 0..16
  function automatic logic [16:0] exp2_neg(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/som_bmu_search_and_update.sv
// Top level of the self-organizing map training block: node store, search, update.
// Depends on som_pkg, som_ram, som_lane, som_isqrt and som_gain.
//
//  channel   | signals                           | handshake
//  ----------+-----------------------------------+-------------------------------
//  request   | start, busy, req_i                | taken when start && !busy
//  response  | resp_valid_o, resp_o              | one-cycle strobe, no back-pressure
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i  | written on any edge with cfg_we_i
//
// Load: answered the next cycle. Read: answered from S_READ (registered RAM read).
// Train: a search at one node per cycle through the RAM read port and the lane
// pipeline, then the square root, then for each window node a RAM read, the gain
// unit, which produces one quotient bit a cycle, and a write back.
// The result item of a train goes out as the update phase starts; busy stays high
// until the last window node is written back.
// rst_ni clears control and the registers to their defaults; the node store is not
// cleared and must be loaded before use. Results cannot be stalled by the receiver.
`default_nettype none
module som_bmu_search_and_update #(
  parameter int unsigned GRID_ROWS = 32,
  parameter int unsigned GRID_COLS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  som_pkg::req_t                     req_i,
  output logic                              resp_valid_o,
  output som_pkg::resp_t                    resp_o,
  input  logic                              cfg_we_i,
  input  logic [som_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [som_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import som_pkg::*;

  localparam int unsigned RW = $clog2(GRID_ROWS);
  localparam int unsigned CW = $clog2(GRID_COLS);
  localparam int unsigned AW = $clog2(GRID_ROWS * GRID_COLS);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_READ     = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_SQRT     = 7'b0001000,
    S_UPD_RD   = 7'b0010000,
    S_UPD_GAIN = 7'b0100000,
    S_UPD_WR   = 7'b1000000
  } state_e;

  function automatic logic [AW-1:0] addr_of(input logic [5:0] r, input logic [5:0] c);
    return AW'(r) * AW'(GRID_COLS) + AW'(c);
  endfunction

  // ---------------------------------------------------------------- config
  logic [5:0]  rows_q, cols_q;
  logic [2:0]  feat_q;
  logic [15:0] alpha_q;
  logic [4:0]  rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 6'd32;
      cols_q  <= 6'd32;
      feat_q  <= 3'd4;
      alpha_q <= 16'hFFFF;
      rad_q   <= 5'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS:   rows_q  <= cfg_wdata_i[5:0];
        CFG_COLS:   cols_q  <= cfg_wdata_i[5:0];
        CFG_FEATS:  feat_q  <= cfg_wdata_i[2:0];
        CFG_ALPHA:  alpha_q <= cfg_wdata_i;
        CFG_RADIUS: rad_q   <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // last active row/col, with zero acting as one and oversize saturating
  logic [RW-1:0]    last_r;
  logic [CW-1:0]    last_c;
  logic [LANES-1:0] used;

  always_comb begin
    if (rows_q == '0) begin
      last_r = '0;
    end else if (7'(rows_q) > 7'(GRID_ROWS)) begin
      last_r = RW'(GRID_ROWS - 1);
    end else begin
      last_r = RW'(rows_q - 6'd1);
    end
    if (cols_q == '0) begin
      last_c = '0;
    end else if (7'(cols_q) > 7'(GRID_COLS)) begin
      last_c = CW'(GRID_COLS - 1);
    end else begin
      last_c = CW'(cols_q - 6'd1);
    end
  end

  // lane 0 always takes part; feat_q above LANES enables them all
  for (genvar k = 0; k < LANES; k++) begin : g_used
    assign used[k] = (k == 0) || (3'(k) < feat_q);
  end

  // ---------------------------------------------------------------- state
  state_e           state_q;
  logic             accept, in_grid;
  logic [VEC_W-1:0] sample_q;
  logic             read_ok_q;

  logic [RW-1:0]    sr_q, p1_r_q, p2_r_q, br_q, ur_q, r1_q;
  logic [CW-1:0]    sc_q, p1_c_q, p2_c_q, bc_q, uc_q, c0_q, c1_q;
  logic             issue_done_q, p1_v_q, p2_v_q, have_q;
  logic [SUM_W-1:0] best_q, sum;

  logic             resp_valid_q;
  resp_t            resp_q;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign in_grid = (7'(req_i.node_row) < 7'(GRID_ROWS)) &&
                   (7'(req_i.node_col) < 7'(GRID_COLS));

  // ---------------------------------------------------------------- store
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VEC_W-1:0] ram_wdata, ram_rdata, upd_word;

  som_ram #(
    .WIDTH (VEC_W),
    .DEPTH (GRID_ROWS * GRID_COLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- lanes
  logic [SQ_W-1:0] sq [LANES];
  logic [GAIN_W-1:0] gain;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    som_lane u_lane (
      .clk_i  (clk_i),
      .x_i    (sample_q[k*LANE_W +: LANE_W]),
      .w_i    (ram_rdata[k*LANE_W +: LANE_W]),
      .used_i (used[k]),
      .gain_i (gain),
      .sq_o   (sq[k]),
      .upd_o  (upd_word[k*LANE_W +: LANE_W])
    );
  end

  // merge: sum of lane distances
  always_comb begin
    sum = '0;
    for (int k = 0; k < LANES; k++) begin
      sum = sum + SUM_W'(sq[k]);
    end
  end

  // ---------------------------------------------------------------- sqrt, gain
  logic              sqrt_start, sqrt_done, gain_start, gain_done;
  logic [ROOT_W-1:0] root;
  logic [4:0]        dr, dc;
  logic [9:0]        dr2, dc2;
  logic [D2_W-1:0]   d2;

  som_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .n_i     (best_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign dr  = (ur_q > br_q) ? 5'(ur_q - br_q) : 5'(br_q - ur_q);
  assign dc  = (uc_q > bc_q) ? 5'(uc_q - bc_q) : 5'(bc_q - uc_q);
  assign dr2 = 10'(dr) * 10'(dr);
  assign dc2 = 10'(dc) * 10'(dc);
  assign d2  = D2_W'(dr2) + D2_W'(dc2);

  som_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gain_start),
    .d2_i    (d2),
    .alpha_i (alpha_q),
    .done_o  (gain_done),
    .gain_o  (gain)
  );

  // window bounds around the winner, clipped to the active grid
  logic [7:0] brx, bcx, radx, r0x, r1x, c0x, c1x;
  assign brx  = 8'(br_q);
  assign bcx  = 8'(bc_q);
  assign radx = 8'(rad_q);
  assign r0x  = (brx > radx) ? brx - radx : 8'd0;
  assign c0x  = (bcx > radx) ? bcx - radx : 8'd0;
  assign r1x  = (brx + radx > 8'(last_r)) ? 8'(last_r) : brx + radx;
  assign c1x  = (bcx + radx > 8'(last_c)) ? 8'(last_c) : bcx + radx;

  // ---------------------------------------------------------------- port control
  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = addr_of(6'(ur_q), 6'(uc_q));
    ram_raddr  = addr_of(6'(ur_q), 6'(uc_q));
    ram_wdata  = upd_word;
    sqrt_start = 1'b0;
    gain_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        ram_waddr = addr_of(6'(req_i.node_row), 6'(req_i.node_col));
        ram_raddr = addr_of(6'(req_i.node_row), 6'(req_i.node_col));
        ram_wdata = req_i.feature_vector;
        ram_we    = accept && in_grid && (req_i.req_type == REQ_LOAD);
        ram_re    = accept && in_grid && (req_i.req_type == REQ_READ);
      end
      S_SCAN: begin
        ram_raddr  = addr_of(6'(sr_q), 6'(sc_q));
        ram_re     = !issue_done_q;
        sqrt_start = issue_done_q && !p1_v_q && !p2_v_q;
      end
      S_UPD_RD: begin
        ram_re     = 1'b1;
        gain_start = 1'b1;
      end
      S_UPD_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      resp_valid_q <= 1'b0;
      resp_q       <= '0;
      sample_q     <= '0;
      read_ok_q    <= 1'b0;
      sr_q         <= '0;
      sc_q         <= '0;
      issue_done_q <= 1'b0;
      p1_v_q       <= 1'b0;
      p2_v_q       <= 1'b0;
      p1_r_q       <= '0;
      p1_c_q       <= '0;
      p2_r_q       <= '0;
      p2_c_q       <= '0;
      have_q       <= 1'b0;
      best_q       <= '0;
      br_q         <= '0;
      bc_q         <= '0;
      ur_q         <= '0;
      uc_q         <= '0;
      r1_q         <= '0;
      c0_q         <= '0;
      c1_q         <= '0;
    end else begin
      resp_valid_q <= 1'b0;
      // search pipeline: address issue -> RAM data -> lane squares -> compare
      p1_v_q <= (state_q == S_SCAN) && !issue_done_q;
      p1_r_q <= sr_q;
      p1_c_q <= sc_q;
      p2_v_q <= p1_v_q;
      p2_r_q <= p1_r_q;
      p2_c_q <= p1_c_q;
      if (p2_v_q && (!have_q || sum < best_q)) begin
        have_q <= 1'b1;
        best_q <= sum;
        br_q   <= p2_r_q;
        bc_q   <= p2_c_q;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req_i.req_type)
              REQ_TRAIN: begin
                sample_q     <= req_i.feature_vector;
                sr_q         <= '0;
                sc_q         <= '0;
                issue_done_q <= 1'b0;
                have_q       <= 1'b0;
                state_q      <= S_SCAN;
              end
              REQ_READ: begin
                read_ok_q <= in_grid;
                state_q   <= S_READ;
              end
              default: begin
                resp_valid_q <= 1'b1;
                resp_q       <= '{resp_kind: req_i.req_type, default: '0};
              end
            endcase
          end
        end
        S_READ: begin
          resp_valid_q <= 1'b1;
          resp_q       <= '{resp_kind:   REQ_READ,
                            node_vector: read_ok_q ? ram_rdata : '0,
                            default:     '0};
          state_q      <= S_IDLE;
        end
        S_SCAN: begin
          if (!issue_done_q) begin
            if (sc_q == last_c) begin
              sc_q <= '0;
              if (sr_q == last_r) begin
                issue_done_q <= 1'b1;
              end else begin
                sr_q <= sr_q + RW'(1);
              end
            end else begin
              sc_q <= sc_q + CW'(1);
            end
          end else if (!p1_v_q && !p2_v_q) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            resp_valid_q <= 1'b1;
            resp_q       <= '{resp_kind:    REQ_TRAIN,
                              bmu_row:      5'(br_q),
                              bmu_col:      5'(bc_q),
                              bmu_distance: (ROOT_W'(root) > ROOT_W'(DIST_MAX)) ?
                                            DIST_MAX : DIST_W'(root),
                              node_vector:  '0};
            ur_q    <= RW'(r0x);
            uc_q    <= CW'(c0x);
            r1_q    <= RW'(r1x);
            c0_q    <= CW'(c0x);
            c1_q    <= CW'(c1x);
            state_q <= S_UPD_RD;
          end
        end
        S_UPD_RD: state_q <= S_UPD_GAIN;
        S_UPD_GAIN: begin
          if (gain_done) begin
            state_q <= S_UPD_WR;
          end
        end
        S_UPD_WR: begin
          if (uc_q == c1_q) begin
            uc_q <= c0_q;
            if (ur_q == r1_q) begin
              state_q <= S_IDLE;
            end else begin
              ur_q    <= ur_q + RW'(1);
              state_q <= S_UPD_RD;
            end
          end else begin
            uc_q    <= uc_q + CW'(1);
            state_q <= S_UPD_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign resp_valid_o = resp_valid_q;
  assign resp_o       = resp_q;

  // ---------------------------------------------------------------- checks
  a_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SQRT) |-> !ram_we)
    else $error("node store written during search");

  a_pipe_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_v_q |-> state_q == S_SCAN)
    else $error("search pipeline active outside scan");

  a_best_stable_in_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT && $past(state_q == S_SQRT)) |-> $stable(best_q))
    else $error("best distance changed during square root");

  a_train_resp_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resp_valid_q && resp_q.resp_kind == REQ_TRAIN) |-> state_q == S_UPD_RD)
    else $error("train result without update phase");

  a_write_after_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD_WR |-> $past(state_q == S_UPD_GAIN) && $past(gain_done))
    else $error("window write without fresh gain");

endmodule
`default_nettype wire

FILE: hw/rtl/som_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module som_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/som_lane.sv
// One feature lane: registered squared difference and the weight update.
// Depends on som_pkg.
`default_nettype none
module som_lane (
  input  logic                             clk_i,
  input  logic [som_pkg::LANE_W-1:0]       x_i,
  input  logic [som_pkg::LANE_W-1:0]       w_i,
  input  logic                             used_i,
  input  logic [som_pkg::GAIN_W-1:0]       gain_i,
  output logic [som_pkg::SQ_W-1:0]         sq_o,
  output logic [som_pkg::LANE_W-1:0]       upd_o
);
  import som_pkg::*;

  logic signed [LANE_W:0]          diff;
  logic signed [2*LANE_W+1:0]      sq_full;
  logic signed [LANE_W+GAIN_W+1:0] prod;
  logic signed [LANE_W+GAIN_W+1:0] rnd;
  logic signed [LANE_W+1:0]        delta;
  logic signed [LANE_W+2:0]        nv;
  logic [SQ_W-1:0]                 sq_q;

  assign diff    = $signed({x_i[LANE_W-1], x_i}) - $signed({w_i[LANE_W-1], w_i});
  assign sq_full = diff * diff;

  always_ff @(posedge clk_i) begin
    sq_q <= used_i ? sq_full[SQ_W-1:0] : '0;
  end
  assign sq_o = sq_q;

  // round half up, floor shift by 16
  assign prod  = diff * $signed({1'b0, gain_i});
  assign rnd   = prod + $signed((LANE_W+GAIN_W+2)'(1 << 15));
  assign delta = rnd[LANE_W+GAIN_W+1:16];
  assign nv    = $signed({{3{w_i[LANE_W-1]}}, w_i}) + $signed({delta[LANE_W+1], delta});

  always_comb begin
    if (!used_i) begin
      upd_o = w_i;
    end else if (nv[LANE_W+2:LANE_W-1] == '0 || nv[LANE_W+2:LANE_W-1] == '1) begin
      upd_o = nv[LANE_W-1:0];
    end else if (nv[LANE_W+2]) begin
      upd_o = {1'b1, {(LANE_W-1){1'b0}}};
    end else begin
      upd_o = {1'b0, {(LANE_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/som_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on som_pkg.
`default_nettype none
module som_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [som_pkg::SUM_W-1:0]    n_i,
  output logic                         done_o,
  output logic [som_pkg::ROOT_W-1:0]   root_o
);
  import som_pkg::*;

  logic [SUM_W-1:0] n_q, r_q, bit_q, trial;
  logic             run_q, done_q;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        n_q   <= n_i;
        r_q   <= '0;
        bit_q <= SUM_W'(1) << (SUM_W - 2);
      end else if (run_q) begin
        if (n_q >= trial) begin
          n_q <= n_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/som_gain.sv
// Neighborhood gain alpha * 2^(-t), t = d2*log2(e)/(2*alpha^2), one quotient bit a cycle.
// Depends on som_pkg.
`default_nettype none
module som_gain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [som_pkg::D2_W-1:0]    d2_i,
  input  logic [15:0]                 alpha_i,
  output logic                        done_o,
  output logic [som_pkg::GAIN_W-1:0]  gain_o
);
  import som_pkg::*;

  localparam int unsigned NW = 60;
  localparam int unsigned QW = 21;

  typedef enum logic [4:0] {
    G_IDLE = 5'b00001,
    G_PRE  = 5'b00010,
    G_DIV  = 5'b00100,
    G_EXP  = 5'b01000,
    G_MUL  = 5'b10000
  } gstate_e;

  gstate_e              state_q;
  logic [NW-1:0]        rem_q, ds_q, lim;
  logic [32:0]          d_q;
  logic                 az_q;
  logic [QW-1:0]        q_q;
  logic [4:0]           cnt_q;
  logic [16:0]          v_q, t0, t1, v_lin;
  logic [28:0]          slope;
  logic [32:0]          gprod;
  logic [GAIN_W-1:0]    gain_q;
  logic                 done_q;

  // quotient of 17*2^16 or more means gain 0
  assign lim = ((NW'(d_q) << 4) + NW'(d_q)) << 16;

  assign t0    = exp2_neg({1'b0, q_q[15:12]});
  assign t1    = exp2_neg(5'({1'b0, q_q[15:12]}) + 5'd1);
  assign slope = 29'(t0 - t1) * 29'(q_q[11:0]);
  assign v_lin = t0 - 17'(slope >> 12);
  assign gprod = 33'(alpha_i) * 33'(v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
      gain_q  <= '0;
      rem_q   <= '0;
      ds_q    <= '0;
      d_q     <= '0;
      az_q    <= 1'b0;
      q_q     <= '0;
      cnt_q   <= '0;
      v_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        G_IDLE: begin
          if (start_i) begin
            rem_q   <= (NW'(d2_i) * NW'(LOG2E_Q16)) << 32;
            d_q     <= {32'(alpha_i) * 32'(alpha_i), 1'b0};
            az_q    <= (alpha_i == '0);
            state_q <= G_PRE;
          end
        end
        G_PRE: begin
          if (az_q || rem_q >= lim) begin
            gain_q  <= '0;
            done_q  <= 1'b1;
            state_q <= G_IDLE;
          end else begin
            ds_q    <= NW'(d_q) << (QW - 1);
            q_q     <= '0;
            cnt_q   <= 5'(QW - 1);
            state_q <= G_DIV;
          end
        end
        G_DIV: begin
          if (rem_q >= ds_q) begin
            rem_q <= rem_q - ds_q;
            q_q   <= (q_q << 1) | QW'(1);
          end else begin
            q_q <= q_q << 1;
          end
          ds_q  <= ds_q >> 1;
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            state_q <= G_EXP;
          end
        end
        G_EXP: begin
          v_q     <= v_lin >> q_q[20:16];
          state_q <= G_MUL;
        end
        G_MUL: begin
          gain_q  <= gprod[31:16];
          done_q  <= 1'b1;
          state_q <= G_IDLE;
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign gain_o = gain_q;

endmodule
`default_nettype wire
